FILE: src/cfms_pkg.sv
package cfms_pkg;

  // fixed point format of the actuator command
  localparam int FRAC_BITS = 16;
  localparam int CMD_W     = 23;
  localparam int DIV_W     = 7;
  localparam int PASS_W    = 5;
  localparam int PCNT_W    = 4;
  localparam int COST_W    = 32;
  localparam int PROD_W    = CMD_W + DIV_W;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [CMD_W-1:0]  FULL_SCALE = CMD_W'(100 << FRAC_BITS);
  localparam logic [CMD_W-1:0]  COARSE_SPAN = CMD_W'(100);
  localparam logic [DIV_W-1:0]  DIV_MIN    = DIV_W'(2);
  localparam logic [PASS_W-1:0] PASS_MAX   = PASS_W'(16);
  localparam logic [PASS_W-1:0] PASS_MIN   = PASS_W'(1);
  localparam logic [DIV_W-1:0]  DIV_RESET  = DIV_W'(10);
  localparam logic [PASS_W-1:0] PASS_RESET = PASS_W'(3);

  // register word addresses (paddr bit 2)
  localparam logic REG_DIVISIONS = 1'b0;
  localparam logic REG_PASSES    = 1'b1;

  // request type codes
  localparam logic REQ_START   = 1'b0;
  localparam logic REQ_MEASURE = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [COST_W-1:0] measurement;
  } req_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             final_res;
    logic             ignored;
  } res_t;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_START,
    OP_IGNORE,
    OP_MEASURE,
    OP_ADVANCE,
    OP_FINISH,
    OP_PASS_END,
    OP_SET_STEP0,
    OP_SET_STEP,
    OP_MUL,
    OP_RECENTER,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic req_type;
    logic running;
    logic point_end;
    logic last_pass;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: src/coarse_fine_min_search.sv
// request steps: capture, decide, then a grid step, a finish or a pass end; a start
// and a pass end wait on the bit-serial divider, and a pass end then recenters
// one request is in work at a time; the next is taken the cycle after the result
// is loaded into the output register, which may still be waiting on res_stall
// reset (rst, synchronous): search idle, divisions 10, passes 3, best cost all ones
module coarse_fine_min_search
  import cfms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  req_t              req_data,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [DIV_W-1:0]  divisions;
  logic [PASS_W-1:0] passes;
  logic [DIV_W-1:0]  eff_div;
  logic [PASS_W-1:0] eff_passes;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign pready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      divisions <= DIV_RESET;
      passes    <= PASS_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_DIVISIONS) begin
        divisions <= pwdata[DIV_W-1:0];
      end else begin
        passes <= pwdata[PASS_W-1:0];
      end
    end
  end

  // register readback
  always_comb begin
    if (paddr[2] == REG_PASSES) begin
      prdata = DATA_W'(passes);
    end else begin
      prdata = DATA_W'(divisions);
    end
  end

  // effective values: divisions at least 2, passes within 1 to 16
  always_comb begin
    eff_div = (divisions < DIV_MIN) ? DIV_MIN : divisions;
    if (passes == '0) begin
      eff_passes = PASS_MIN;
    end else if (passes > PASS_MAX) begin
      eff_passes = PASS_MAX;
    end else begin
      eff_passes = passes;
    end
  end

  cfms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cfms_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req_data   (req_data),
    .eff_div    (eff_div),
    .eff_passes (eff_passes),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
  );

endmodule

FILE: src/cfms_div.sv
module cfms_div
  import cfms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [CMD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(CMD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [CMD_W-1:0] quot;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   trial;
  logic             ge;

  // one quotient bit per cycle, restoring form
  always_comb begin
    trial = {rem, quot[CMD_W-1]};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        quot <= {quot[CMD_W-2:0], ge};
        rem  <= ge ? DIV_W'(trial - {1'b0, dsr}) : trial[DIV_W-1:0];
        cnt  <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(CMD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quotient = quot;

endmodule

FILE: src/cfms_dp.sv
module cfms_dp
  import cfms_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  req_t              req_data,
  input  logic [DIV_W-1:0]  eff_div,
  input  logic [PASS_W-1:0] eff_passes,
  output logic              res_valid,
  input  logic              res_stall,
  output res_t              res_data
);

  req_t              req_q;
  logic              running;
  logic [PCNT_W-1:0] pass_count;
  logic [DIV_W-1:0]  point_index;
  logic [CMD_W-1:0]  step_size;
  logic [CMD_W-1:0]  current_command;
  logic [COST_W-1:0] best_cost;
  logic [CMD_W-1:0]  best_command;
  logic [PROD_W-1:0] prod;
  logic              fin;
  logic              ign;

  logic              div_start;
  logic [CMD_W-1:0]  div_dividend;
  logic              div_done;
  logic [CMD_W-1:0]  div_quot;
  logic [CMD_W:0]    adv_sum;
  logic [CMD_W-1:0]  adv_next;
  logic [PROD_W-2:0] half;
  logic [CMD_W-1:0]  recenter_next;
  logic [PASS_W-1:0] pass_inc;

  // shared divider: coarse step at start, refinement at pass end
  assign div_start    = (cmd.op == OP_START) || (cmd.op == OP_PASS_END);
  assign div_dividend = (cmd.op == OP_START) ? COARSE_SPAN : step_size;

  cfms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (eff_div),
    .done     (div_done),
    .quotient (div_quot)
  );

  // next grid point, saturated at full scale
  always_comb begin
    adv_sum  = {1'b0, current_command} + {1'b0, step_size};
    adv_next = (adv_sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : adv_sum[CMD_W-1:0];
  end

  // new pass start: best minus half span, clamped to zero and full scale
  always_comb begin
    half = prod[PROD_W-1:1];
    if ({{(PROD_W-1-CMD_W){1'b0}}, best_command} > half) begin
      recenter_next = best_command - half[CMD_W-1:0];
    end else begin
      recenter_next = '0;
    end
    if (recenter_next > FULL_SCALE) begin
      recenter_next = FULL_SCALE;
    end
  end

  assign pass_inc = {1'b0, pass_count} + PASS_W'(1);

  // status to the controller
  always_comb begin
    status.req_type  = req_q.req_type;
    status.running   = running;
    status.point_end = (point_index >= eff_div);
    status.last_pass = (pass_inc >= eff_passes);
    status.div_done  = div_done;
    status.out_free  = !res_valid || !res_stall;
  end

  // search state
  always_ff @(posedge clk) begin
    if (rst) begin
      running         <= 1'b0;
      pass_count      <= '0;
      point_index     <= '0;
      step_size       <= '0;
      current_command <= '0;
      best_cost       <= '1;
      best_command    <= '0;
      fin             <= 1'b0;
      ign             <= 1'b0;
    end else begin
      case (cmd.op)
        OP_CAPTURE: begin
          req_q <= req_data;
          fin   <= 1'b0;
          ign   <= 1'b0;
        end
        OP_START: begin
          running         <= 1'b1;
          pass_count      <= '0;
          point_index     <= '0;
          current_command <= '0;
          best_cost       <= '1;
          best_command    <= '0;
        end
        OP_IGNORE: begin
          ign <= 1'b1;
        end
        OP_MEASURE: begin
          if ((point_index == '0) || (req_q.measurement < best_cost)) begin
            best_cost    <= req_q.measurement;
            best_command <= current_command;
          end
        end
        OP_ADVANCE: begin
          point_index     <= point_index + DIV_W'(1);
          current_command <= adv_next;
        end
        OP_FINISH: begin
          pass_count      <= pass_inc[PCNT_W-1:0];
          running         <= 1'b0;
          current_command <= best_command;
          fin             <= 1'b1;
        end
        OP_PASS_END: begin
          pass_count <= pass_inc[PCNT_W-1:0];
        end
        OP_SET_STEP0: begin
          step_size <= CMD_W'(div_quot << FRAC_BITS);
        end
        OP_SET_STEP: begin
          step_size <= div_quot;
        end
        OP_MUL: begin
          prod <= PROD_W'(eff_div) * PROD_W'(step_size);
        end
        OP_RECENTER: begin
          current_command <= recenter_next;
          point_index     <= '0;
          best_cost       <= '1;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      res_valid          <= 1'b1;
      res_data.command   <= current_command;
      res_data.final_res <= fin;
      res_data.ignored   <= ign;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  a_cmd_in_range: assert property (@(posedge clk) disable iff (rst)
    current_command <= FULL_SCALE)
    else $error("command above full scale");

  a_finish_stops: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |=> (!running && fin && current_command == $past(best_command)))
    else $error("search end did not stop at best command");
`endif

endmodule

FILE: src/cfms_ctrl.sv
module cfms_ctrl
  import cfms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_STEP,
    S_WAIT_STEP0,
    S_WAIT_STEP,
    S_MUL,
    S_RECENTER,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = (state != S_IDLE);

  // next state and datapath operation
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = OP_CAPTURE;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.req_type == REQ_START) begin
          cmd.op     = OP_START;
          state_next = S_WAIT_STEP0;
        end else if (!status.running) begin
          cmd.op     = OP_IGNORE;
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_MEASURE;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (!status.point_end) begin
          cmd.op     = OP_ADVANCE;
          state_next = S_EMIT;
        end else if (status.last_pass) begin
          cmd.op     = OP_FINISH;
          state_next = S_EMIT;
        end else begin
          cmd.op     = OP_PASS_END;
          state_next = S_WAIT_STEP;
        end
      end
      S_WAIT_STEP0: begin
        if (status.div_done) begin
          cmd.op     = OP_SET_STEP0;
          state_next = S_EMIT;
        end
      end
      S_WAIT_STEP: begin
        if (status.div_done) begin
          cmd.op     = OP_SET_STEP;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_RECENTER;
      end
      S_RECENTER: begin
        cmd.op     = OP_RECENTER;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_WAIT_STEP0 || state == S_WAIT_STEP))
    else $error("divider finished with nobody waiting");

  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !status.out_free) |=> (state == S_EMIT))
    else $error("result dropped while output busy");
`endif

endmodule
